>>> rtl/core/adp_pkg.sv
// ----------------------------------------------------------------------------
// adp_pkg
// Shared types, constants and datapath step functions of the AdaDelta update.
// ----------------------------------------------------------------------------
package adp_pkg;

	localparam int IDX_W           = 10;
	localparam int DATA_W          = 32;
	localparam int MEAN_W          = 48;
	localparam int LR_W            = 16;
	localparam int RHO_W           = 17;
	localparam int BIAS_W          = 32;
	localparam int CFG_IDX_W       = 2;
	localparam int PARAM_COUNT_DEF = 1024;
	localparam int IDX_SPAN        = 2 ** IDX_W;

	localparam logic [RHO_W-1:0]  ONE_Q16     = 17'd65536;
	localparam logic [LR_W-1:0]   LR_RESET    = 16'd65;
	localparam logic [RHO_W-1:0]  RHO_RESET   = 17'd62259;
	localparam logic [BIAS_W-1:0] BIAS_RESET  = 32'd4295;

	// pipeline stage numbers, stage 1 holds the accepted item
	localparam int ROOT_STAGES = 32;
	localparam int DIV_STAGES  = 32;
	localparam int ST_AB       = 5;
	localparam int ST_ROOT     = ST_AB + ROOT_STAGES;
	localparam int ST_N        = ST_ROOT + 1;
	localparam int ST_Q        = ST_N + DIV_STAGES;
	localparam int ST_R        = ST_Q + 1;
	localparam int ST_M        = ST_R + 1;
	localparam int PIPE_DEPTH  = ST_M + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEARNING_RATE = 2'd0,
		REG_DECAY_RHO     = 2'd1,
		REG_EPSILON_BIAS  = 2'd2
	} cfg_reg_e;

	typedef struct packed {
		logic [MEAN_W-1:0] m;
		logic [MEAN_W-1:0] d;
	} mean_pair_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		mean_pair_t        data;
	} mem_wr_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] value;
		logic              sat;
	} result_t;

	typedef struct packed {
		logic [63:0] x;
		logic [34:0] rem;
		logic [31:0] res;
	} sq_t;

	typedef struct packed {
		logic [31:0] den;
		logic [31:0] rem;
		logic [31:0] nlo;
		logic [31:0] q;
		logic        ovf;
	} dv_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic              inrange;
		logic              gneg;
		logic [31:0]       gmag;
		logic [31:0]       p;
		logic              sat;
		logic [MEAN_W-1:0] gsq;
		logic [63:0]       mr;
		logic [63:0]       dr;
		logic [63:0]       rg;
		logic [63:0]       a;
		logic [MEAN_W-1:0] mp;
		logic [63:0]       b;
		logic [31:0]       sa;
		logic [31:0]       sb;
		logic [63:0]       n;
		logic [31:0]       rmag;
		logic              rneg;
		logic [MEAN_W-1:0] rsq;
		logic [31:0]       step;
		logic [63:0]       rg2;
		logic [31:0]       nv;
	} pl_t;

	// one digit of the integer square root
	function automatic sq_t sq_step(input sq_t s);
		logic [34:0] sh;
		logic [34:0] t;
		sq_t o;
		sh = {s.rem[32:0], s.x[63:62]};
		t = {1'b0, s.res, 2'b01};
		o.x = {s.x[61:0], 2'b00};
		if (sh >= t) begin
			o.rem = sh - t;
			o.res = {s.res[30:0], 1'b1};
		end else begin
			o.rem = sh;
			o.res = {s.res[30:0], 1'b0};
		end
		return o;
	endfunction

	// one quotient bit of the restoring divider
	function automatic dv_t dv_step(input dv_t s);
		logic [32:0] sh;
		logic [32:0] diff;
		dv_t o;
		sh = {s.rem, s.nlo[31]};
		diff = sh - {1'b0, s.den};
		o = s;
		o.nlo = {s.nlo[30:0], 1'b0};
		if (sh >= {1'b0, s.den}) begin
			o.rem = diff[31:0];
			o.q = {s.q[30:0], 1'b1};
		end else begin
			o.rem = sh[31:0];
			o.q = {s.q[30:0], 1'b0};
		end
		return o;
	endfunction

endpackage

>>> rtl/core/adp_if.sv
// ----------------------------------------------------------------------------
// adp_if
// Handshake channels of the AdaDelta update: items, results, register writes.
// ----------------------------------------------------------------------------
interface adp_item_if;
	logic                      valid;
	logic                      ready;
	logic [adp_pkg::IDX_W-1:0] param_index;
	logic signed [31:0]        gradient;
	logic signed [31:0]        param_value;

	modport source (output valid, param_index, gradient, param_value, input ready);
	modport sink   (input valid, param_index, gradient, param_value, output ready);
endinterface

interface adp_result_if;
	logic                      valid;
	logic                      ready;
	logic [adp_pkg::IDX_W-1:0] out_index;
	logic signed [31:0]        new_value;
	logic                      saturated;

	modport source (output valid, out_index, new_value, saturated, input ready);
	modport sink   (input valid, out_index, new_value, saturated, output ready);
endinterface

interface adp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [adp_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/adadelta_parameter_update_top.sv
// ----------------------------------------------------------------------------
// adadelta_parameter_update_top: AdaDelta update of one parameter per transaction
// Takes one item per cycle while the result queue has room and the clearing sweep is
// done, except that an item whose index is still in flight waits for that writeback.
// Reset clears the mean memory in a sweep over its min(PARAM_COUNT, 1024) entries.
// ----------------------------------------------------------------------------
module adadelta_parameter_update_top #(
	parameter int PARAM_COUNT = adp_pkg::PARAM_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	adp_item_if.sink     item,
	adp_result_if.source result,
	adp_cfg_if.sink      cfg
);

	// memory covers only the indices that can be addressed
	localparam int DEPTH = (PARAM_COUNT < adp_pkg::IDX_SPAN) ? PARAM_COUNT : adp_pkg::IDX_SPAN;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PD    = adp_pkg::PIPE_DEPTH;

	// configuration registers
	logic [adp_pkg::LR_W-1:0]   lr_q;
	logic [adp_pkg::RHO_W-1:0]  rho_q;
	logic [adp_pkg::BIAS_W-1:0] bias_q;
	logic [adp_pkg::RHO_W-1:0]  rho;
	logic [adp_pkg::RHO_W-1:0]  omr;

	// pipeline
	adp_pkg::pl_t        pl_q  [1:PD];
	adp_pkg::pl_t        nxt   [1:PD];
	logic [PD:1]         v_q;
	logic                adv;
	logic                accept;
	logic                hit;
	logic                in_range;
	logic                clr_done;
	adp_pkg::mean_pair_t rd_data;
	adp_pkg::mem_wr_t    wr;
	adp_pkg::result_t    res;
	logic                can_push;
	logic [31:0]         root_a;
	logic [31:0]         root_b;
	logic [31:0]         quo;
	logic                ovf;
	logic [64:0]         dsum;

	// ------------------------------------------------------------------
	// Configuration: the user must issue writes only while idle; the
	// block does not enforce this. Every stage reads the registers directly.
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= adp_pkg::LR_RESET;
			rho_q  <= adp_pkg::RHO_RESET;
			bias_q <= adp_pkg::BIAS_RESET;
		end else if (cfg.valid) begin
			unique case (adp_pkg::cfg_reg_e'(cfg.index))
				adp_pkg::REG_LEARNING_RATE: lr_q <= cfg.data[adp_pkg::LR_W-1:0];
				adp_pkg::REG_DECAY_RHO:     rho_q <= cfg.data[adp_pkg::RHO_W-1:0];
				adp_pkg::REG_EPSILON_BIAS:  bias_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// rho above one acts as one
	assign rho = (rho_q > adp_pkg::ONE_Q16) ? adp_pkg::ONE_Q16 : rho_q;
	assign omr = adp_pkg::ONE_Q16 - rho;

	// ------------------------------------------------------------------
	// Input handshake. The whole pipeline moves together on adv; an item
	// waits while an earlier item to the same index is in flight, up to
	// and including the cycle of its writeback (read-modify-write interlock).
	// ------------------------------------------------------------------
	assign adv      = can_push;
	assign in_range = (32'(item.param_index) < PARAM_COUNT);

	always_comb begin
		hit = 1'b0;
		for (int k = 1; k <= PD; k++) begin
			hit = hit | (v_q[k] & pl_q[k].inrange & (pl_q[k].idx == item.param_index));
		end
	end

	assign item.ready = adv & ~hit & clr_done;
	assign accept     = item.valid & item.ready;

	adp_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (item.param_index[AW-1:0]),
		.rd_data (rd_data),
		.wr      (wr),
		.clr_done(clr_done)
	);

	// ------------------------------------------------------------------
	// Stage logic: each stage copies the previous one and fills in what
	// it computes.
	// ------------------------------------------------------------------
	always_comb begin
		logic [63:0]               prod;
		logic [47:0]               lprod;
		logic [adp_pkg::MEAN_W-1:0] m;
		logic [adp_pkg::MEAN_W-1:0] d;
		logic [64:0]               sum;
		logic [31:0]               lim;
		logic [33:0]               ext;
		logic [33:0]               s34;

		// stage 1: accepted item
		nxt[1]         = '0;
		nxt[1].idx     = item.param_index;
		nxt[1].inrange = in_range;
		nxt[1].gneg    = item.gradient[31];
		nxt[1].gmag    = item.gradient[31] ? (32'd0 - item.gradient) : item.gradient;
		nxt[1].p       = item.param_value;

		for (int k = 2; k <= PD; k++) begin
			nxt[k] = pl_q[k-1];
		end

		// stage 2: square of g, decayed old means, root argument of the update mean
		m = pl_q[1].inrange ? rd_data.m : '0;
		d = pl_q[1].inrange ? rd_data.d : '0;
		prod = 64'(pl_q[1].gmag) * 64'(pl_q[1].gmag);
		nxt[2].gsq = prod[63:16];
		nxt[2].mr  = 64'(m) * 64'(rho);
		nxt[2].dr  = 64'(d) * 64'(rho);
		sum = {1'b0, d, 16'h0000} + 65'(bias_q);
		nxt[2].a   = sum[64] ? '1 : sum[63:0];
		nxt[2].sat = pl_q[1].sat | sum[64];

		// stage 3: weight of the new square
		nxt[3].rg = 64'(omr) * 64'(pl_q[2].gsq);

		// stage 4: new gradient mean
		sum = 65'(pl_q[3].mr) + 65'(pl_q[3].rg);
		nxt[4].mp = sum[63:16];

		// stage 5: root argument of the gradient mean
		sum = {1'b0, pl_q[4].mp, 16'h0000} + 65'(bias_q);
		nxt[adp_pkg::ST_AB].b   = sum[64] ? '1 : sum[63:0];
		nxt[adp_pkg::ST_AB].sat = pl_q[4].sat | sum[64];

		// roots arrive alongside stage ST_ROOT; numerator of the ratio
		nxt[adp_pkg::ST_N].sa = root_a;
		nxt[adp_pkg::ST_N].sb = root_b;
		nxt[adp_pkg::ST_N].n  = 64'(pl_q[adp_pkg::ST_ROOT].gmag) * 64'(root_a);

		// quotient arrives alongside stage ST_Q; clip to the signed range
		lim = pl_q[adp_pkg::ST_Q].gneg ? 32'h8000_0000 : 32'h7fff_ffff;
		if (pl_q[adp_pkg::ST_Q].sb == '0) begin
			if (pl_q[adp_pkg::ST_Q].gmag == '0 || pl_q[adp_pkg::ST_Q].sa == '0) begin
				nxt[adp_pkg::ST_R].rmag = '0;
			end else begin
				nxt[adp_pkg::ST_R].rmag = lim;
				nxt[adp_pkg::ST_R].sat  = 1'b1;
			end
		end else if (ovf || quo > lim) begin
			nxt[adp_pkg::ST_R].rmag = lim;
			nxt[adp_pkg::ST_R].sat  = 1'b1;
		end else begin
			nxt[adp_pkg::ST_R].rmag = quo;
		end
		nxt[adp_pkg::ST_R].rneg = pl_q[adp_pkg::ST_Q].gneg & (nxt[adp_pkg::ST_R].rmag != '0);

		// square of the update and scaled step
		prod  = 64'(pl_q[adp_pkg::ST_R].rmag) * 64'(pl_q[adp_pkg::ST_R].rmag);
		lprod = 48'(lr_q) * 48'(pl_q[adp_pkg::ST_R].rmag);
		nxt[adp_pkg::ST_M].rsq  = prod[63:16];
		nxt[adp_pkg::ST_M].step = lprod[47:16];

		// last stage: weight of the new update square, new parameter value
		nxt[PD].rg2 = 64'(omr) * 64'(pl_q[adp_pkg::ST_M].rsq);
		ext = {{2{pl_q[adp_pkg::ST_M].p[31]}}, pl_q[adp_pkg::ST_M].p};
		s34 = pl_q[adp_pkg::ST_M].rneg ? (ext + {2'b00, pl_q[adp_pkg::ST_M].step})
		                               : (ext - {2'b00, pl_q[adp_pkg::ST_M].step});
		if (s34[33:31] != 3'b000 && s34[33:31] != 3'b111) begin
			nxt[PD].nv  = s34[33] ? 32'h8000_0000 : 32'h7fff_ffff;
			nxt[PD].sat = 1'b1;
		end else begin
			nxt[PD].nv = s34[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[PD-1:1], accept};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 1; k <= PD; k++) begin
				pl_q[k] <= nxt[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Pipelined long-latency units: both roots, then the ratio divider.
	// ------------------------------------------------------------------
	adp_root u_root_a (
		.clk (clk),
		.en  (adv),
		.x   (pl_q[adp_pkg::ST_AB].a),
		.root(root_a)
	);

	adp_root u_root_b (
		.clk (clk),
		.en  (adv),
		.x   (pl_q[adp_pkg::ST_AB].b),
		.root(root_b)
	);

	adp_div u_div (
		.clk(clk),
		.en (adv),
		.num(pl_q[adp_pkg::ST_N].n),
		.den(pl_q[adp_pkg::ST_N].sb),
		.quo(quo),
		.ovf(ovf)
	);

	// ------------------------------------------------------------------
	// Writeback of both means and result push happen on the same edge.
	// ------------------------------------------------------------------
	assign dsum = 65'(pl_q[PD].dr) + 65'(pl_q[PD].rg2);

	always_comb begin
		wr.en     = adv & v_q[PD] & pl_q[PD].inrange;
		wr.addr   = pl_q[PD].idx;
		wr.data.m = pl_q[PD].mp;
		wr.data.d = dsum[63:16];
	end

	always_comb begin
		res.idx   = pl_q[PD].idx;
		res.value = pl_q[PD].nv;
		res.sat   = pl_q[PD].sat;
	end

	adp_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (adv & v_q[PD]),
		.push_data(res),
		.can_push (can_push),
		.result   (result)
	);

endmodule

>>> rtl/core/adp_mem.sv
// ----------------------------------------------------------------------------
// adp_mem
// State memory of both running means, with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module adp_mem #(
	parameter int DEPTH = adp_pkg::PARAM_COUNT_DEF,
	parameter int AW    = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output adp_pkg::mean_pair_t rd_data,
	input  adp_pkg::mem_wr_t    wr,
	output logic                clr_done
);

	adp_pkg::mean_pair_t mem [DEPTH];
	adp_pkg::mean_pair_t rd_q;
	logic                clr_act_q;
	logic [AW-1:0]       clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_act_q  <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_act_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_act_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_q;
	assign clr_done = ~clr_act_q;

endmodule

>>> rtl/core/adp_root.sv
// ----------------------------------------------------------------------------
// adp_root
// Pipelined 64-bit integer square root, one result digit per stage.
// ----------------------------------------------------------------------------
module adp_root (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] x,
	output logic [31:0] root
);

	adp_pkg::sq_t st_q [adp_pkg::ROOT_STAGES];
	adp_pkg::sq_t init;

	always_comb begin
		init.x   = x;
		init.rem = '0;
		init.res = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0] <= adp_pkg::sq_step(init);
			for (int k = 1; k < adp_pkg::ROOT_STAGES; k++) begin
				st_q[k] <= adp_pkg::sq_step(st_q[k-1]);
			end
		end
	end

	assign root = st_q[adp_pkg::ROOT_STAGES-1].res;

endmodule

>>> rtl/core/adp_div.sv
// ----------------------------------------------------------------------------
// adp_div
// Pipelined restoring divider, 64 by 32 bits, 32 quotient bits plus overflow.
// ----------------------------------------------------------------------------
module adp_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic [31:0] quo,
	output logic        ovf
);

	adp_pkg::dv_t st_q [adp_pkg::DIV_STAGES];
	adp_pkg::dv_t init;

	always_comb begin
		init.den = den;
		init.rem = num[63:32];
		init.nlo = num[31:0];
		init.q   = '0;
		// quotient needs more than 32 bits
		init.ovf = (num[63:32] >= den);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0] <= adp_pkg::dv_step(init);
			for (int k = 1; k < adp_pkg::DIV_STAGES; k++) begin
				st_q[k] <= adp_pkg::dv_step(st_q[k-1]);
			end
		end
	end

	assign quo = st_q[adp_pkg::DIV_STAGES-1].q;
	assign ovf = st_q[adp_pkg::DIV_STAGES-1].ovf;

endmodule

>>> rtl/core/adp_outq.sv
// ----------------------------------------------------------------------------
// adp_outq
// Two-entry result queue that decouples the pipeline from the result channel.
// ----------------------------------------------------------------------------
module adp_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  adp_pkg::result_t push_data,
	output logic             can_push,
	adp_result_if.source     result
);

	adp_pkg::result_t ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign pop      = result.valid & result.ready;
	assign can_push = (cnt_q != 2'd2) | pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	assign result.valid     = (cnt_q != 2'd0);
	assign result.out_index = ent_q[rd_ptr_q].idx;
	assign result.new_value = ent_q[rd_ptr_q].value;
	assign result.saturated = ent_q[rd_ptr_q].sat;

endmodule

>>> rtl/core/adp_checker.sv
// ----------------------------------------------------------------------------
// adp_checker
// Port-level checks of the AdaDelta update, bound to the top level.
// ----------------------------------------------------------------------------
module adp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [adp_pkg::IDX_W-1:0] out_index,
	input logic [31:0]               new_value,
	input logic                      saturated
);

	localparam int MAX_OPEN = adp_pkg::PIPE_DEPTH + 2;

	logic [6:0] open_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + {6'd0, in_acc} - {6'd0, out_acc};
		end
	end

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (open_q != '0))
		else $error("result transaction without an open item");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 7'(MAX_OPEN))
		else $error("more items open than pipeline and queue can hold");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			($stable(out_index) && $stable(new_value) && $stable(saturated)))
		else $error("result payload changed while stalled");

endmodule

bind adadelta_parameter_update_top adp_checker u_adp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (item.valid),
	.in_ready (item.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_index(result.out_index),
	.new_value(result.new_value),
	.saturated(result.saturated)
);
